### hdl/lift_shake_retract_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lift/shake/retract sequencer
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef LIFT_SHAKE_RETRACT_SEQUENCER_ASSERT_SVH
`define LIFT_SHAKE_RETRACT_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define LSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication
`define LSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

### hdl/lsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_pkg
// Widths, register indexes and shared types of the lift/shake/retract
// sequencer.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int POSITION_BITS = 24;
    localparam int TIMER_BITS    = 16;
    localparam int AMP_BITS      = 16;
    localparam int ELAPSED_BITS  = TIMER_BITS + 1;

    // wide enough for lift +/- amplitude without overflow
    localparam int SUM_BITS = ((POSITION_BITS > AMP_BITS + 1) ?
                               POSITION_BITS : (AMP_BITS + 1)) + 1;

    localparam int CFG_DATA_BITS  = (POSITION_BITS > AMP_BITS) ?
                                    ((POSITION_BITS > TIMER_BITS) ? POSITION_BITS : TIMER_BITS) :
                                    ((AMP_BITS > TIMER_BITS) ? AMP_BITS : TIMER_BITS);
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIFT_POSITION     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHAKE_AMPLITUDE   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHAKE_DURATION_MS = 2'd2;

    localparam logic [TIMER_BITS-1:0] SHAKE_DURATION_RESET = TIMER_BITS'(4000);

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] lift_position;
        logic [AMP_BITS-1:0]             shake_amplitude;
        logic [TIMER_BITS-1:0]           shake_duration_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0] target_position;
        logic                            fast_profile;
        logic                            drive_enabled;
        logic                            busy_res;
        logic                            deploy_taken;
    } res_t;

endpackage : lsr_pkg
`default_nettype wire

### hdl/lsr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_cfg
// Configuration register file: lift position, shake amplitude and shake
// duration, written one beat at a time by index.
// ----------------------------------------------------------------------------
module lsr_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [lsr_pkg::CFG_INDEX_BITS-1:0]    wr_index,
    input  wire logic [lsr_pkg::CFG_DATA_BITS-1:0]     wr_data,
    output lsr_pkg::cfg_t                              cfg
);

    lsr_pkg::cfg_t cfg_reg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lift_position     <= '0;
            cfg_reg.shake_amplitude   <= '0;
            cfg_reg.shake_duration_ms <= lsr_pkg::SHAKE_DURATION_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lsr_pkg::REG_LIFT_POSITION:
                    cfg_reg.lift_position <= wr_data[lsr_pkg::POSITION_BITS-1:0];
                lsr_pkg::REG_SHAKE_AMPLITUDE:
                    cfg_reg.shake_amplitude <= wr_data[lsr_pkg::AMP_BITS-1:0];
                lsr_pkg::REG_SHAKE_DURATION_MS:
                    cfg_reg.shake_duration_ms <= wr_data[lsr_pkg::TIMER_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : lsr_cfg
`default_nettype wire

### hdl/lsr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_core
// Phase state machine and shake timer. On each step it consumes one loop
// beat and presents the updated command as a result.
// ----------------------------------------------------------------------------
module lsr_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          deploy_request,
    input  wire logic          at_target,
    input  wire logic          ms_tick,
    input  wire lsr_pkg::cfg_t cfg,
    output lsr_pkg::res_t      res
);

    localparam int PB = lsr_pkg::POSITION_BITS;
    localparam int SB = lsr_pkg::SUM_BITS;
    localparam int EB = lsr_pkg::ELAPSED_BITS;

    localparam logic signed [SB-1:0] POS_MAX_EXT = SB'((64'sd1 <<< (PB - 1)) - 64'sd1);
    localparam logic signed [SB-1:0] POS_MIN_EXT = SB'(-(64'sd1 <<< (PB - 1)));

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_LIFT    = 2'd1,
        PH_SHAKE   = 2'd2,
        PH_RETRACT = 2'd3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic                   going_up_reg, going_up_next;
    logic [EB-1:0]          elapsed_reg, elapsed_next, elapsed_tick;
    logic signed [PB-1:0]   target_reg, target_next;
    logic                   fast_reg, fast_next;
    logic                   on_reg, on_next;
    logic                   taken;

    logic signed [SB-1:0]   lift_ext, amp_ext, sum_up, sum_dn;
    logic signed [PB-1:0]   shake_hi, shake_lo;

    // shake excursions, clamped to the position range
    always_comb
    begin
        lift_ext = {{(SB - PB){cfg.lift_position[PB-1]}}, cfg.lift_position};
        amp_ext  = {{(SB - lsr_pkg::AMP_BITS){1'b0}}, cfg.shake_amplitude};
        sum_up   = lift_ext + amp_ext;
        sum_dn   = lift_ext - amp_ext;
        if (sum_up > POS_MAX_EXT)
            shake_hi = POS_MAX_EXT[PB-1:0];
        else
            shake_hi = sum_up[PB-1:0];
        if (sum_dn < POS_MIN_EXT)
            shake_lo = POS_MIN_EXT[PB-1:0];
        else
            shake_lo = sum_dn[PB-1:0];
    end

    // saturating millisecond count
    assign elapsed_tick = (ms_tick && (elapsed_reg != {EB{1'b1}})) ?
                          elapsed_reg + EB'(1) : elapsed_reg;

    // phase transitions
    always_comb
    begin
        phase_next    = phase_reg;
        going_up_next = going_up_reg;
        elapsed_next  = elapsed_reg;
        target_next   = target_reg;
        fast_next     = fast_reg;
        on_next       = on_reg;
        taken         = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (deploy_request)
                begin
                    taken       = 1'b1;
                    fast_next   = 1'b0;
                    on_next     = 1'b1;
                    target_next = cfg.lift_position;
                    phase_next  = PH_LIFT;
                end
            end
            PH_LIFT:
            begin
                if (at_target)
                begin
                    fast_next     = 1'b1;
                    elapsed_next  = '0;
                    going_up_next = 1'b0;
                    phase_next    = PH_SHAKE;
                end
            end
            PH_SHAKE:
            begin
                elapsed_next = elapsed_tick;
                if (at_target)
                begin
                    if (elapsed_tick > {1'b0, cfg.shake_duration_ms})
                    begin
                        phase_next  = PH_RETRACT;
                        fast_next   = 1'b0;
                        target_next = '0;
                    end
                    else if (going_up_reg)
                    begin
                        going_up_next = 1'b0;
                        target_next   = shake_lo;
                    end
                    else
                    begin
                        going_up_next = 1'b1;
                        target_next   = shake_hi;
                    end
                end
            end
            default:
            begin
                if (at_target)
                begin
                    phase_next = PH_IDLE;
                    on_next    = 1'b0;
                end
            end
        endcase
    end

    // state holds between steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            going_up_reg <= 1'b0;
            elapsed_reg  <= '0;
            target_reg   <= '0;
            fast_reg     <= 1'b0;
            on_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            going_up_reg <= going_up_next;
            elapsed_reg  <= elapsed_next;
            target_reg   <= target_next;
            fast_reg     <= fast_next;
            on_reg       <= on_next;
        end
    end

    // result reflects the state after this beat
    always_comb
    begin
        res.target_position = target_next;
        res.fast_profile    = fast_next;
        res.drive_enabled   = on_next;
        res.busy_res        = (phase_next != PH_IDLE);
        res.deploy_taken    = taken;
    end

endmodule : lsr_core
`default_nettype wire

### hdl/lift_shake_retract_sequencer.sv
// From input beat to result beat: the input register, then the result
// register, with the phase update between them.
// Throughput: one beat per cycle; the input register advances whenever the
// result register is empty or being drained in the same cycle.
// Reset: asynchronous, active low; phase idle, out_valid low, lift 0,
// amplitude 0, shake duration 4000 ms. Usable in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lift_shake_retract_sequencer
// Top level: loop-step input register, phase core, config registers and
// result register for a stepper-driven dumper.
// ----------------------------------------------------------------------------
`include "lift_shake_retract_sequencer_assert.svh"

module lift_shake_retract_sequencer (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    // configuration
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [lsr_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
    input  wire logic [lsr_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    // loop step in
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire logic                                       deploy_request,
    input  wire logic                                       at_target,
    input  wire logic                                       ms_tick,
    // command out
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output logic signed [lsr_pkg::POSITION_BITS-1:0]        target_position,
    output logic                                            fast_profile,
    output logic                                            drive_enabled,
    output logic                                            busy_res,
    output logic                                            deploy_taken
);

    lsr_pkg::cfg_t cfg;
    lsr_pkg::res_t res;
    lsr_pkg::res_t res_reg;

    logic s1_valid_reg;
    logic s1_req_reg, s1_arr_reg, s1_tick_reg;
    logic out_valid_reg;
    logic advance;

    assign cfg_ready = 1'b1;

    // pipeline control
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    lsr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lsr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .deploy_request (s1_req_reg),
        .at_target      (s1_arr_reg),
        .ms_tick        (s1_tick_reg),
        .cfg            (cfg),
        .res            (res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg  <= deploy_request;
            s1_arr_reg  <= at_target;
            s1_tick_reg <= ms_tick;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res;
    end

    assign out_valid       = out_valid_reg;
    assign target_position = res_reg.target_position;
    assign fast_profile    = res_reg.fast_profile;
    assign drive_enabled   = res_reg.drive_enabled;
    assign busy_res        = res_reg.busy_res;
    assign deploy_taken    = res_reg.deploy_taken;

    // checks
    `LSR_ASSERT_NOW(a_idle_quiet, out_valid_reg && !res_reg.busy_res, !res_reg.drive_enabled && !res_reg.fast_profile)
    `LSR_ASSERT_NOW(a_busy_enabled, out_valid_reg && res_reg.busy_res, res_reg.drive_enabled)
    `LSR_ASSERT_NOW(a_taken_starts_lift, out_valid_reg && res_reg.deploy_taken, res_reg.busy_res && !res_reg.fast_profile)
    `LSR_ASSERT_NEXT(a_step_fills_result, advance, out_valid_reg)

endmodule : lift_shake_retract_sequencer
`default_nettype wire

### test/tb_lift_shake_retract_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lift_shake_retract_sequencer
// Self-checking bench for the dumper sequencer. A driver offers loop steps
// from a queue and a monitor predicts the command for each accepted step,
// then checks command beats against it in order. Register settings change
// between batches while nothing is in flight. Both sides idle at random; one
// batch runs against a long receiver hold.
// ----------------------------------------------------------------------------
module tb_lift_shake_retract_sequencer;

    localparam int PB = lsr_pkg::POSITION_BITS;
    localparam int DB = lsr_pkg::CFG_DATA_BITS;
    localparam int IB = lsr_pkg::CFG_INDEX_BITS;
    localparam int AB = lsr_pkg::AMP_BITS;
    localparam int TB = lsr_pkg::TIMER_BITS;
    localparam int EB = lsr_pkg::ELAPSED_BITS;

    localparam logic [IB-1:0] REG_SPARE = 2'd3;
    localparam longint POS_HI = (longint'(1) <<< (PB - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 8;

    typedef enum logic [1:0] {ARM_IDLE, ARM_LIFT, ARM_SHAKE, ARM_RETRACT} arm_phase_t;

    typedef struct packed {
        logic req;
        logic arrived;
        logic tick;
    } loop_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [IB-1:0]                 cfg_index = lsr_pkg::REG_LIFT_POSITION;
    logic [DB-1:0]                 cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          deploy_request = 1'b0;
    logic                          at_target = 1'b0;
    logic                          ms_tick = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [PB-1:0]          target_position;
    logic                          fast_profile;
    logic                          drive_enabled;
    logic                          busy_res;
    logic                          deploy_taken;

    lift_shake_retract_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .deploy_request (deploy_request),
        .at_target      (at_target),
        .ms_tick        (ms_tick),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .target_position(target_position),
        .fast_profile   (fast_profile),
        .drive_enabled  (drive_enabled),
        .busy_res       (busy_res),
        .deploy_taken   (deploy_taken)
    );

    // register mirror
    logic signed [PB-1:0]            lift_pos = '0;
    logic [AB-1:0]                   shake_amp = '0;
    logic [TB-1:0]                   shake_ms = lsr_pkg::SHAKE_DURATION_RESET;

    // sequencer state mirror
    arm_phase_t                      arm_phase = ARM_IDLE;
    logic                            shake_up = 1'b0;
    logic [EB-1:0]                   elapsed_ms = '0;
    logic signed [PB-1:0]            cmd_target = '0;
    logic                            cmd_fast = 1'b0;
    logic                            drive_on = 1'b0;

    loop_step_t     pending_steps[$];
    lsr_pkg::res_t  command_q[$];
    int unsigned steps_queued = 0;
    int unsigned steps_taken = 0;
    int unsigned cfg_beats = 0;
    int unsigned mismatches = 0;
    int unsigned quiet = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic        step_fired = 1'b0;
    logic        calm = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // next command for one loop step; advances the state mirror
    function automatic lsr_pkg::res_t next_command(input loop_step_t s);
        lsr_pkg::res_t r;
        longint        swing;
        r.deploy_taken = 1'b0;
        case (arm_phase)
            ARM_IDLE:
                if (s.req)
                begin
                    r.deploy_taken = 1'b1;
                    cmd_fast   = 1'b0;
                    drive_on   = 1'b1;
                    cmd_target = lift_pos;
                    arm_phase  = ARM_LIFT;
                end
            ARM_LIFT:
                if (s.arrived)
                begin
                    cmd_fast   = 1'b1;
                    elapsed_ms = '0;
                    shake_up   = 1'b0;
                    arm_phase  = ARM_SHAKE;
                end
            ARM_SHAKE:
            begin
                // ms counter saturates
                if (s.tick && elapsed_ms != '1)
                    elapsed_ms = elapsed_ms + 1'b1;
                if (s.arrived)
                begin
                    if (elapsed_ms > shake_ms)
                    begin
                        arm_phase  = ARM_RETRACT;
                        cmd_fast   = 1'b0;
                        cmd_target = '0;
                    end
                    else
                    begin
                        swing = shake_up ? longint'(lift_pos) - longint'(shake_amp)
                                         : longint'(lift_pos) + longint'(shake_amp);
                        if (swing > POS_HI)
                            swing = POS_HI;
                        else if (swing < POS_LO)
                            swing = POS_LO;
                        shake_up   = !shake_up;
                        cmd_target = PB'(swing);
                    end
                end
            end
            default:
                if (s.arrived)
                begin
                    arm_phase = ARM_IDLE;
                    drive_on  = 1'b0;
                end
        endcase
        r.target_position = cmd_target;
        r.fast_profile    = cmd_fast;
        r.drive_enabled   = drive_on;
        r.busy_res        = (arm_phase != ARM_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // monitor: predicts on step beats, checks command beats, tracks config
    always @(posedge clk)
    begin
        lsr_pkg::res_t want;
        loop_step_t    seen;
        logic          cmd_fired;
        logic          cfg_fired;
        step_fired = in_valid && in_ready;
        cmd_fired  = out_valid && out_ready;
        cfg_fired  = cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cmd_fired)
            begin
                if (command_q.size() == 0)
                    report_mismatch("command beat with nothing pending", 1, 0);
                else
                begin
                    want = command_q.pop_front();
                    if (target_position !== want.target_position)
                        report_mismatch("target_position", longint'(target_position),
                                        longint'(want.target_position));
                    if (fast_profile !== want.fast_profile)
                        report_mismatch("fast_profile", fast_profile, want.fast_profile);
                    if (drive_enabled !== want.drive_enabled)
                        report_mismatch("drive_enabled", drive_enabled, want.drive_enabled);
                    if (busy_res !== want.busy_res)
                        report_mismatch("busy_res", busy_res, want.busy_res);
                    if (deploy_taken !== want.deploy_taken)
                        report_mismatch("deploy_taken", deploy_taken, want.deploy_taken);
                end
            end
            if (cfg_fired)
            begin
                cfg_beats++;
                case (cfg_index)
                    lsr_pkg::REG_LIFT_POSITION:     lift_pos  = cfg_data[PB-1:0];
                    lsr_pkg::REG_SHAKE_AMPLITUDE:   shake_amp = cfg_data[AB-1:0];
                    lsr_pkg::REG_SHAKE_DURATION_MS: shake_ms  = cfg_data[TB-1:0];
                    default: ;
                endcase
            end
            if (step_fired)
            begin
                seen = '{req: deploy_request, arrived: at_target, tick: ms_tick};
                command_q.push_back(next_command(seen));
                steps_taken++;
            end
            // watchdog on cycles with no beat at all
            if (step_fired || cmd_fired || cfg_fired)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb_lift_shake_retract_sequencer: errors");
                $finish;
            end
        end
    end

    // step driver
    always @(negedge clk)
    begin
        loop_step_t nxt;
        if (rst_n && (!in_valid || step_fired))
        begin
            if (pending_steps.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = pending_steps.pop_front();
                in_valid       <= 1'b1;
                deploy_request <= nxt.req;
                at_target      <= nxt.arrived;
                ms_tick        <= nxt.tick;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // command receiver, with a long hold on request
    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic queue_step(input logic req, input logic arrived, input logic tick);
        pending_steps.push_back('{req: req, arrived: arrived, tick: tick});
        steps_queued++;
    endtask

    task automatic write_reg(input logic [IB-1:0] idx,
                             input logic [DB-1:0] data);
        int unsigned mark;
        mark = cfg_beats;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (cfg_beats == mark);
        cfg_valid <= 1'b0;
    endtask

    // wait until every step is taken and every command checked
    task automatic drain();
        while (steps_taken != steps_queued || command_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic loop_step_t random_step(input bit shaped);
        loop_step_t s;
        if (shaped)
        begin
            s.req     = ($urandom_range(0, 99) < 50);
            s.arrived = ($urandom_range(0, 99) < 35);
            s.tick    = ($urandom_range(0, 99) < 70);
        end
        else
            s = loop_step_t'(3'($urandom));
        return s;
    endfunction

    initial
    begin
        logic [DB-1:0] word;
        loop_step_t    st;
        int unsigned   batch;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle steps at reset settings
        @(posedge clk);
        queue_step(1'b0, 1'b0, 1'b0);
        queue_step(1'b0, 1'b1, 1'b1);
        drain();

        // top lift, full amplitude: plus excursion clamps high
        write_reg(lsr_pkg::REG_LIFT_POSITION, DB'(POS_HI));
        write_reg(lsr_pkg::REG_SHAKE_AMPLITUDE, DB'(16'hFFFF));
        write_reg(lsr_pkg::REG_SHAKE_DURATION_MS, DB'(2));
        @(posedge clk);
        queue_step(1'b1, 1'b0, 1'b0);   // consumed, lift
        queue_step(1'b1, 1'b0, 1'b1);   // request and tick ignored while lifting
        queue_step(1'b0, 1'b1, 1'b1);   // arrive: shake
        queue_step(1'b0, 1'b1, 1'b1);   // plus
        queue_step(1'b0, 1'b1, 1'b1);   // minus
        queue_step(1'b0, 1'b0, 1'b1);   // time only
        queue_step(1'b1, 1'b1, 1'b0);   // past duration: retract
        queue_step(1'b1, 1'b1, 1'b0);   // home, idle
        queue_step(1'b1, 1'b0, 1'b0);   // held request starts a new cycle
        queue_step(1'b0, 1'b1, 1'b0);   // shake again
        queue_step(1'b0, 1'b1, 1'b0);   // starts with plus
        queue_step(1'b0, 1'b1, 1'b0);
        queue_step(1'b0, 1'b1, 1'b1);
        drain();

        // bottom lift, zero duration: minus excursion clamps low
        write_reg(lsr_pkg::REG_LIFT_POSITION, DB'(POS_LO));
        write_reg(lsr_pkg::REG_SHAKE_DURATION_MS, DB'(0));
        @(posedge clk);
        queue_step(1'b0, 1'b1, 1'b0);   // past duration: retract
        queue_step(1'b0, 1'b1, 1'b1);   // home, idle
        queue_step(1'b0, 1'b1, 1'b0);   // idle
        queue_step(1'b1, 1'b0, 1'b0);
        queue_step(1'b0, 1'b1, 1'b0);
        queue_step(1'b0, 1'b1, 1'b0);
        queue_step(1'b0, 1'b1, 1'b0);
        queue_step(1'b0, 1'b1, 1'b1);
        queue_step(1'b0, 1'b1, 1'b0);
        drain();

        // random batches under varying settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       word = DB'(POS_HI);
                1:       word = DB'(POS_LO);
                2:       word = '0;
                3:       word = DB'($urandom_range(0, 40000)) - 24'd20000;
                default: word = DB'($urandom);
            endcase
            write_reg(lsr_pkg::REG_LIFT_POSITION, word);

            word = DB'($urandom);
            case ($urandom_range(0, 3))
                0:       word[AB-1:0] = '0;
                1:       word[AB-1:0] = '1;
                default: ;
            endcase
            write_reg(lsr_pkg::REG_SHAKE_AMPLITUDE, word);

            word = DB'($urandom);
            case (ph)
                3:       word[TB-1:0] = '1;
                5:       word[TB-1:0] = 16'd120;
                7:       word[TB-1:0] = lsr_pkg::SHAKE_DURATION_RESET;
                8:       word[TB-1:0] = '0;
                default: word[TB-1:0] = TB'($urandom_range(0, 24));
            endcase
            write_reg(lsr_pkg::REG_SHAKE_DURATION_MS, word);

            if (ph == 6)
                write_reg(REG_SPARE, DB'($urandom));

            batch = (ph == 5) ? 250 : 125;
            @(posedge clk);
            calm = (ph == 2 || ph == 5);
            // receiver stalls while the driver keeps offering
            if (ph == 4)
                hold_asked++;
            for (int k = 0; k < batch; k++)
            begin
                st = random_step($urandom_range(0, 99) < 85);
                queue_step(st.req, st.arrived, st.tick);
            end
            drain();
        end

        @(posedge clk);
        calm = 1'b0;
        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("tb_lift_shake_retract_sequencer: clean");
        else
            $display("tb_lift_shake_retract_sequencer: errors");
        $finish;
    end

endmodule
